>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Screen geometry, character codes, register indexes and the payload
// structs of the input, result and internal control channels.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
    localparam int TAB_STOP   = 8;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0F20;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST   = 8'h7F;

    // Control characters
    typedef enum logic [CHAR_W-1:0] {
        CHAR_BS  = 8'h08,
        CHAR_TAB = 8'h09,
        CHAR_LF  = 8'h0A,
        CHAR_CR  = 8'h0D
    } ctrl_char_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKGROUND = 4'd0,
        CFG_BLANK_FORE = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fore_color;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_location;
        logic              cell_written;
        logic [ADDR_W-1:0] cell_address;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } out_item_t;

    // Cursor unit result for one character
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] loc;
        logic              written;
        logic [ADDR_W-1:0] addr;
        logic              scroll;
    } cursor_step_t;

    // Cell write request from the top level into the store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } cell_wr_t;

    // Scroll start request
    typedef struct packed {
        logic              start;
        logic [CELL_W-1:0] blank;
    } scroll_cmd_t;

    // Cell word: background nibble, foreground nibble, character
    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOR_W-1:0] back,
        input logic [COLOR_W-1:0] fore,
        input logic [CHAR_W-1:0]  ch
    );
        return {back, fore, ch};
    endfunction

endpackage

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor: cursor registers and per-character cursor update
// Decodes the character, moves the cursor, wraps columns, folds a row
// overflow back onto the last row and flags the scroll.
// ----------------------------------------------------------------------------
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [CHAR_W-1:0] char_code,
    output cursor_step_t      step
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W:0]   col_w;
    logic [ROW_W:0]   row_w;
    logic             printable;

    assign printable = (char_code >= CHAR_SPACE) && (char_code <= CHAR_LAST);

    // Character decode and cursor arithmetic
    always_comb begin
        col_w        = {1'b0, col_reg};
        row_w        = {1'b0, row_reg};
        step.written = 1'b0;
        step.addr    = '0;
        step.scroll  = 1'b0;

        unique case (char_code)
            CHAR_BS: begin
                if (col_reg != '0) begin
                    col_w = col_w - 1'b1;
                end
            end
            CHAR_TAB: begin
                col_w = (col_w + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
            end
            CHAR_CR: begin
                col_w = '0;
            end
            CHAR_LF: begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            default: begin
                if (printable) begin
                    step.written = 1'b1;
                    step.addr    = ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, row_reg}
                                   * ADDR_W'(COLUMNS))
                                   + {{(ADDR_W-COL_W){1'b0}}, col_reg};
                    col_w        = col_w + 1'b1;
                end
            end
        endcase

        // Column wrap
        if (col_w >= (COL_W+1)'(COLUMNS)) begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end

        // Row overflow: stay on the last row and scroll
        if (row_w >= (ROW_W+1)'(ROWS)) begin
            row_w       = (ROW_W+1)'(ROWS - 1);
            step.scroll = 1'b1;
        end

        step.col = col_w[COL_W-1:0];
        step.row = row_w[ROW_W-1:0];
        step.loc = ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, step.row} * ADDR_W'(COLUMNS))
                   + {{(ADDR_W-COL_W){1'b0}}, step.col};

        col_next = step_en ? step.col : col_reg;
        row_next = step_en ? step.row : row_reg;
    end

    // Cursor registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/core/tcw_store.sv
// ----------------------------------------------------------------------------
// tcw_store: screen cell store and its sweep engine
// Owns the cell RAM. After reset it fills every cell with the reset blank.
// On a scroll it copies each cell from one row below and blanks the last
// row, one cell per cycle. Single cell writes pass through when idle.
// ----------------------------------------------------------------------------
module tcw_store
    import tcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_wr_t    cell_wr,
    input  scroll_cmd_t scroll_cmd,
    output logic        busy
);

    logic              run_reg;
    logic              clear_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [CELL_W-1:0] blank_reg;
    logic              pipe_valid_reg;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic              pipe_blank_reg;

    logic              last_cell;
    logic              copy_phase;
    logic [ADDR_W:0]   src_sum;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign last_cell  = (cnt_reg == ADDR_W'(CELL_COUNT - 1));
    assign copy_phase = (cnt_reg < ADDR_W'(MOVE_COUNT));
    assign src_sum    = {1'b0, cnt_reg} + (ADDR_W+1)'(COLUMNS);

    // Read issue: source cell one row below the destination
    assign ram_re    = run_reg && !clear_reg && copy_phase;
    assign ram_raddr = src_sum[ADDR_W-1:0];

    // Write select: scroll pipe, clear pass, then single writes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_wr.addr;
        ram_wdata = cell_wr.data;
        if (pipe_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pipe_addr_reg;
            ram_wdata = pipe_blank_reg ? blank_reg : ram_rdata;
        end else if (run_reg && clear_reg) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = RESET_BLANK;
        end else if (cell_wr.en) begin
            ram_we    = 1'b1;
        end
    end

    // Sweep counter and copy pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b1;
            clear_reg      <= 1'b1;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
        end else begin
            pipe_valid_reg <= run_reg && !clear_reg;
            if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_cell) begin
                    run_reg <= 1'b0;
                end
            end else if (scroll_cmd.start) begin
                run_reg   <= 1'b1;
                clear_reg <= 1'b0;
                cnt_reg   <= '0;
            end
        end
    end

    // Payload of the sweep
    always_ff @(posedge aclk) begin
        pipe_addr_reg  <= cnt_reg;
        pipe_blank_reg <= !copy_phase;
        if (!run_reg && scroll_cmd.start) begin
            blank_reg <= scroll_cmd.blank;
        end
    end

    assign busy = run_reg || pipe_valid_reg;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: character writer for an 80x25 text screen
// Takes one character with a foreground color, stores printable codes in
// the cell RAM, moves the cursor and scrolls the screen when needed.
//
//   Channel  Ports                        Moves
//   input    s_valid s_ready s_data       character and foreground color
//   result   m_valid m_ready m_data       cursor, cell write, scroll flag
//   config   cfg_valid cfg_ready          register index and data
//            cfg_index cfg_data
//
// An ordinary character is accepted and its cell written at the input
// transfer; its result then moves from the pending slot to the output
// register. A scroll occupies the RAM sweep, one cell per cycle with a
// registered read; no input is taken meanwhile.
// After reset a clearing pass writes the blank cell to all 2000 cells
// before the first input transfer; config writes are always taken.
// A stalled result waits in the output register while one more item is taken.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] background_reg, background_next;
    logic [COLOR_W-1:0] blank_fore_reg, blank_fore_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          pend_reg;
    out_item_t          out_reg;

    logic               accept;
    logic               move;
    logic               store_busy;
    logic [CELL_W-1:0]  cell_word;
    cursor_step_t       step;
    cell_wr_t           cell_wr;
    scroll_cmd_t        scroll_cmd;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !store_busy && !pend_valid_reg;
    assign move      = pend_valid_reg && (!out_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // Cursor unit
    tcw_cursor u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .char_code (s_data.char_code),
        .step      (step)
    );

    assign cell_word = make_cell(background_reg, s_data.fore_color, s_data.char_code);

    // Cell write and scroll request at the input transfer
    always_comb begin
        cell_wr.en       = accept && step.written;
        cell_wr.addr     = step.addr;
        cell_wr.data     = cell_word;
        scroll_cmd.start = accept && step.scroll;
        scroll_cmd.blank = make_cell(background_reg, blank_fore_reg, CHAR_SPACE);
    end

    // Cell store with clear and scroll sweeps
    tcw_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cell_wr    (cell_wr),
        .scroll_cmd (scroll_cmd),
        .busy       (store_busy)
    );

    // Configuration register decode
    always_comb begin
        background_next = background_reg;
        blank_fore_next = blank_fore_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BACKGROUND: background_next = cfg_data;
                CFG_BLANK_FORE: blank_fore_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Result staging: pending slot then output register
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (accept) begin
            pend_valid_next = 1'b1;
        end else if (move) begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            background_reg <= '0;
            blank_fore_reg <= 4'hF;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            background_reg <= background_next;
            blank_fore_reg <= blank_fore_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg.cursor_col      <= step.col;
            pend_reg.cursor_row      <= step.row;
            pend_reg.cursor_location <= step.loc;
            pend_reg.cell_written    <= step.written;
            pend_reg.cell_address    <= step.addr;
            pend_reg.cell_value      <= step.written ? cell_word : '0;
            pend_reg.scrolled        <= step.scroll;
        end
        if (move) begin
            out_reg <= pend_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Cursor row stays on screen in every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cursor_row < ROW_W'(ROWS)))
        else $error("cursor row beyond last row");

    // Linear location agrees with row and column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cursor_location ==
            ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, m_data.cursor_row} * ADDR_W'(COLUMNS))
            + {{(ADDR_W-COL_W){1'b0}}, m_data.cursor_col}))
        else $error("cursor location mismatch");

    // A scroll blocks input on the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && step.scroll) |=> (store_busy && !s_ready))
        else $error("input taken during scroll");

    // Cell address and value stay zero in a result without a cell write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.cell_written) |->
            (m_data.cell_address == '0 && m_data.cell_value == '0))
        else $error("cell fields set without a write");

endmodule
